[design/pxr_pkg.sv]
// ----------------------------------------------------------------------------
// pxr_pkg
// Shared constants, types and helper functions for the pixel-to-ground-range
// pipeline: field widths, angle constants, the CORDIC arctangent table and
// the per-step CORDIC operations.
// ----------------------------------------------------------------------------
package pxr_pkg;

  // Field widths and configuration
  localparam int PIXEL_BITS      = 11;
  localparam int ANGLE_FRAC_BITS = 13;
  localparam int CORDIC_STEPS    = 16;
  localparam int STEPS_USED      = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

  localparam int ANGLE_W    = 16;
  localparam int CENTRE_W   = 12;
  localparam int SCALE_W    = 24;
  localparam int OFFSET_W   = 16;
  localparam int HEIGHT_W   = 16;
  localparam int RANGE_W    = 32;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Internal datapath widths
  localparam int DELTA_W = ((CENTRE_W > PIXEL_BITS + 1) ? CENTRE_W : PIXEL_BITS + 1) + 1;
  localparam int PROD_W  = DELTA_W + SCALE_W;
  localparam int VEC_W   = PROD_W + 3;
  localparam int Z_W     = 33;
  localparam int ROT_W   = 34;
  localparam int ANG_SH  = 30 - ANGLE_FRAC_BITS;
  localparam int WRAP_W  = ((ANGLE_W + ANG_SH + 1) > 35) ? (ANGLE_W + ANG_SH + 1) : 35;

  // Q30 angle constants
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30  = 64'sd6746518852;

  // Number of whole turns a scaled input angle can span
  localparam int WRAP_MAX = int'((longint'(1) <<< (ANGLE_W - 1 + ANG_SH)) / TWO_PI_Q30);

  // Gain-compensated start value of the rotation CORDIC
  localparam longint ROT_X0_L = 64'sd652032874
    + ((64'sd434688583 + (longint'(1) <<< (2 * STEPS_USED - 1))) >>> (2 * STEPS_USED));
  localparam logic signed [ROT_W-1:0] ROT_X0 = ROT_W'(ROT_X0_L);

  // Rounding and clamping of Q30 angles to output angles
  localparam logic signed [Z_W-1:0] ANGLE_RND = Z_W'(longint'(1) <<< (ANG_SH - 1));
  localparam logic signed [Z_W-1:0] ANGLE_HI  = Z_W'((longint'(1) <<< (ANGLE_W - 1)) - 1);
  localparam logic signed [Z_W-1:0] ANGLE_LO  = Z_W'(-(longint'(1) <<< (ANGLE_W - 1)));

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTRE_X  = CFG_IDX_W'(0),
    REG_CENTRE_Y  = CFG_IDX_W'(1),
    REG_SCALE_X   = CFG_IDX_W'(2),
    REG_SCALE_Y   = CFG_IDX_W'(3),
    REG_ELEV_OFS  = CFG_IDX_W'(4),
    REG_CAM_HGT   = CFG_IDX_W'(5)
  } cfg_reg_t;

  typedef struct packed {
    logic [CENTRE_W-1:0]        centre_x;
    logic [CENTRE_W-1:0]        centre_y;
    logic [SCALE_W-1:0]         scale_x;
    logic [SCALE_W-1:0]         scale_y;
    logic signed [OFFSET_W-1:0] elev_ofs;
    logic [HEIGHT_W-1:0]        height;
  } cfg_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] bearing;
    logic signed [ANGLE_W-1:0] elevation;
  } angle_pair_t;

  typedef struct packed {
    angle_pair_t              ang;
    logic signed [ROT_W-1:0]  c1;
    logic signed [ROT_W-1:0]  c2;
  } trig_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [Z_W-1:0]   z;
  } vec_t;

  typedef struct packed {
    logic signed [ROT_W-1:0] x;
    logic signed [ROT_W-1:0] y;
    logic signed [ROT_W-1:0] a;
  } rot_t;

  // atan(2^-i) in Q30
  function automatic logic [31:0] atan_q30(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'd843314857;
      1:  v = 32'd497837829;
      2:  v = 32'd263043837;
      3:  v = 32'd133525159;
      4:  v = 32'd67021687;
      5:  v = 32'd33543516;
      6:  v = 32'd16775851;
      7:  v = 32'd8388437;
      8:  v = 32'd4194283;
      9:  v = 32'd2097149;
      10: v = 32'd1048576;
      11: v = 32'd524288;
      12: v = 32'd262144;
      13: v = 32'd131072;
      14: v = 32'd65536;
      15: v = 32'd32768;
      16: v = 32'd16384;
      17: v = 32'd8192;
      18: v = 32'd4096;
      19: v = 32'd2048;
      20: v = 32'd1024;
      21: v = 32'd512;
      22: v = 32'd256;
      23: v = 32'd128;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // One vectoring step: drive y toward zero, accumulate the angle
  function automatic vec_t vec_step(input vec_t s, input int k);
    vec_t r;
    logic signed [VEC_W-1:0] dx;
    logic signed [VEC_W-1:0] dy;
    logic signed [Z_W-1:0]   da;
    dx = $signed(s.y) >>> k;
    dy = $signed(s.x) >>> k;
    da = $signed({1'b0, atan_q30(k)});
    if (!s.y[VEC_W-1]) begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.z = s.z + da;
    end else begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.z = s.z - da;
    end
    return r;
  endfunction

  // One rotation step: drive the residual angle toward zero
  function automatic rot_t rot_step(input rot_t s, input int k);
    rot_t r;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dy;
    logic signed [ROT_W-1:0] da;
    dx = $signed(s.y) >>> k;
    dy = $signed(s.x) >>> k;
    da = $signed(ROT_W'(atan_q30(k)));
    if (!s.a[ROT_W-1]) begin
      r.x = s.x - dx;
      r.y = s.y + dy;
      r.a = s.a - da;
    end else begin
      r.x = s.x + dx;
      r.y = s.y - dy;
      r.a = s.a + da;
    end
    return r;
  endfunction

endpackage

[design/pxr_if.sv]
// ----------------------------------------------------------------------------
// pxr_if
// Valid/ready channels of the block: the pixel channel in and the range
// result channel out.
// ----------------------------------------------------------------------------
interface pxr_pixel_if import pxr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel_x;
  logic [PIXEL_BITS-1:0] pixel_y;

  modport source (output valid, output pixel_x, output pixel_y, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface pxr_result_if import pxr_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] bearing;
  logic signed [ANGLE_W-1:0] elevation;
  logic signed [RANGE_W-1:0] range;
  logic                      range_saturated;

  modport source (output valid, output bearing, output elevation, output range,
                  output range_saturated, input ready);
  modport sink   (input valid, input bearing, input elevation, input range,
                  input range_saturated, output ready);
endinterface

[design/pxr_angle.sv]
// ----------------------------------------------------------------------------
// pxr_angle
// Pixel offsets times scale, then two pipelined vectoring CORDIC lanes that
// give bearing and elevation, rounded and clamped to output angles.
// ----------------------------------------------------------------------------
module pxr_angle import pxr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [PIXEL_BITS-1:0] pixel_x,
  input  logic [PIXEL_BITS-1:0] pixel_y,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  output angle_pair_t           out_ang
);

  localparam int NV = STEPS_USED + 1;

  logic [0:NV]                vld;
  vec_t                       vb [0:STEPS_USED];
  vec_t                       ve [0:STEPS_USED];
  logic signed [DELTA_W-1:0]  dx;
  logic signed [DELTA_W-1:0]  dy;
  logic signed [PROD_W-1:0]   prod_x;
  logic signed [PROD_W-1:0]   prod_y;
  logic signed [Z_W-1:0]      zb_rnd;
  logic signed [Z_W-1:0]      ze_rnd;
  logic signed [Z_W-1:0]      ze_ofs;
  angle_pair_t                ang_next;

  // Valid bits move with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {in_valid, vld[0:NV-1]};
    end
  end

  // Signed half-pixel offsets from the image centre, times scale
  always_comb begin
    dx = $signed({{(DELTA_W - CENTRE_W){1'b0}}, cfg.centre_x})
       - $signed({{(DELTA_W - PIXEL_BITS - 1){1'b0}}, pixel_x, 1'b0});
    dy = $signed({{(DELTA_W - CENTRE_W){1'b0}}, cfg.centre_y})
       - $signed({{(DELTA_W - PIXEL_BITS - 1){1'b0}}, pixel_y, 1'b0});
    prod_x = dx * $signed({1'b0, cfg.scale_x});
    prod_y = dy * $signed({1'b0, cfg.scale_y});
  end

  // Stage 0: CORDIC start vectors
  always_ff @(posedge clk) begin
    if (en) begin
      vb[0].x <= VEC_W'(longint'(1) <<< 25);
      vb[0].y <= VEC_W'(prod_x);
      vb[0].z <= '0;
      ve[0].x <= VEC_W'(longint'(1) <<< 25);
      ve[0].y <= VEC_W'(prod_y);
      ve[0].z <= '0;
    end
  end

  // One vectoring step per stage
  for (genvar k = 0; k < STEPS_USED; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        vb[k+1] <= vec_step(vb[k], k);
        ve[k+1] <= vec_step(ve[k], k);
      end
    end
  end

  // Round to output angle, add elevation correction, clamp
  always_comb begin
    zb_rnd = (vb[STEPS_USED].z + ANGLE_RND) >>> ANG_SH;
    ze_rnd = (ve[STEPS_USED].z + ANGLE_RND) >>> ANG_SH;
    ze_ofs = ze_rnd + Z_W'(cfg.elev_ofs);
    if (zb_rnd > ANGLE_HI) begin
      ang_next.bearing = ANGLE_W'(ANGLE_HI);
    end else if (zb_rnd < ANGLE_LO) begin
      ang_next.bearing = ANGLE_W'(ANGLE_LO);
    end else begin
      ang_next.bearing = ANGLE_W'(zb_rnd);
    end
    if (ze_ofs > ANGLE_HI) begin
      ang_next.elevation = ANGLE_W'(ANGLE_HI);
    end else if (ze_ofs < ANGLE_LO) begin
      ang_next.elevation = ANGLE_W'(ANGLE_LO);
    end else begin
      ang_next.elevation = ANGLE_W'(ze_ofs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ang <= ang_next;
    end
  end

  assign out_valid = vld[NV];

endmodule

[design/pxr_sincos.sv]
// ----------------------------------------------------------------------------
// pxr_sincos
// Range reduction and two pipelined rotation CORDIC lanes: cos(bearing) and
// -sin(elevation), which is cos(pi/2 + elevation), both Q30.
// ----------------------------------------------------------------------------
module pxr_sincos import pxr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  angle_pair_t in_ang,
  output logic        out_valid,
  output trig_t       out_trig
);

  localparam int NV = STEPS_USED + 3;

  localparam logic signed [WRAP_W-1:0] W_PI      = WRAP_W'(PI_Q30);
  localparam logic signed [WRAP_W-1:0] W_TWO_PI  = WRAP_W'(TWO_PI_Q30);
  localparam logic signed [WRAP_W-1:0] W_HALF_PI = WRAP_W'(HALF_PI_Q30);

  logic [0:NV]               vld;
  angle_pair_t               angp [0:STEPS_USED+2];
  logic signed [WRAP_W-1:0]  mod_b;
  logic signed [WRAP_W-1:0]  mod_e;
  logic signed [WRAP_W-1:0]  wrp_b;
  logic signed [WRAP_W-1:0]  wrp_e;
  logic signed [WRAP_W-1:0]  mod_b_w;
  logic signed [WRAP_W-1:0]  mod_e_w;
  rot_t                      rb [0:STEPS_USED];
  rot_t                      re [0:STEPS_USED];
  logic [0:STEPS_USED]       flip_b;
  logic [0:STEPS_USED]       flip_e;
  logic signed [ROT_W-1:0]   cb;
  logic signed [ROT_W-1:0]   se;

  // Truncating remainder by a full turn of the scaled angle
  function automatic logic signed [WRAP_W-1:0] mod_turn(input logic signed [ANGLE_W-1:0] ang);
    logic signed [WRAP_W-1:0] a;
    logic [WRAP_W-1:0]        mag;
    logic [WRAP_W-1:0]        rem;
    a   = WRAP_W'(ang) <<< ANG_SH;
    mag = a[WRAP_W-1] ? WRAP_W'(-a) : WRAP_W'(a);
    rem = mag;
    for (int j = 1; j <= WRAP_MAX; j++) begin
      if (mag >= WRAP_W'(longint'(j) * TWO_PI_Q30)) begin
        rem = mag - WRAP_W'(longint'(j) * TWO_PI_Q30);
      end
    end
    return a[WRAP_W-1] ? -$signed(rem) : $signed(rem);
  endfunction

  // Bring into [-pi, pi]
  function automatic logic signed [WRAP_W-1:0] wrap_pi(input logic signed [WRAP_W-1:0] a);
    logic signed [WRAP_W-1:0] r;
    r = a;
    if (a > W_PI) begin
      r = a - W_TWO_PI;
    end else if (a < -W_PI) begin
      r = a + W_TWO_PI;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {in_valid, vld[0:NV-1]};
    end
  end

  always_comb begin
    mod_b = mod_turn(in_ang.bearing);
    mod_e = mod_turn(in_ang.elevation);
  end

  // Stages 0 and 1: turn remainder, then wrap to half a turn
  always_ff @(posedge clk) begin
    if (en) begin
      angp[0] <= in_ang;
      wrp_b   <= mod_b;
      wrp_e   <= mod_e;
      angp[1] <= angp[0];
      mod_b_w <= wrap_pi(wrp_b);
      mod_e_w <= wrap_pi(wrp_e);
    end
  end

  // Stage 2: fold into [-pi/2, pi/2] and remember the sign flip
  always_ff @(posedge clk) begin
    if (en) begin
      angp[2] <= angp[1];
      rb[0].x <= ROT_X0;
      rb[0].y <= '0;
      re[0].x <= ROT_X0;
      re[0].y <= '0;
      if (mod_b_w > W_HALF_PI) begin
        rb[0].a   <= ROT_W'(mod_b_w - W_PI);
        flip_b[0] <= 1'b1;
      end else if (mod_b_w < -W_HALF_PI) begin
        rb[0].a   <= ROT_W'(mod_b_w + W_PI);
        flip_b[0] <= 1'b1;
      end else begin
        rb[0].a   <= ROT_W'(mod_b_w);
        flip_b[0] <= 1'b0;
      end
      if (mod_e_w > W_HALF_PI) begin
        re[0].a   <= ROT_W'(mod_e_w - W_PI);
        flip_e[0] <= 1'b1;
      end else if (mod_e_w < -W_HALF_PI) begin
        re[0].a   <= ROT_W'(mod_e_w + W_PI);
        flip_e[0] <= 1'b1;
      end else begin
        re[0].a   <= ROT_W'(mod_e_w);
        flip_e[0] <= 1'b0;
      end
    end
  end

  // One rotation step per stage
  for (genvar k = 0; k < STEPS_USED; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        rb[k+1]     <= rot_step(rb[k], k);
        re[k+1]     <= rot_step(re[k], k);
        flip_b[k+1] <= flip_b[k];
        flip_e[k+1] <= flip_e[k];
        angp[k+3]   <= angp[k+2];
      end
    end
  end

  // Undo the fold and form the two cosines
  always_comb begin
    cb = flip_b[STEPS_USED] ? -rb[STEPS_USED].x : rb[STEPS_USED].x;
    se = flip_e[STEPS_USED] ? -re[STEPS_USED].y : re[STEPS_USED].y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_trig.ang <= angp[STEPS_USED+2];
      out_trig.c1  <= -se;
      out_trig.c2  <= cb;
    end
  end

  assign out_valid = vld[NV];

endmodule

[design/pxr_div.sv]
// ----------------------------------------------------------------------------
// pxr_div
// Two pipelined restoring dividers, one quotient bit per stage:
// height * 2^38 / |c1|, then that quotient * 2^30 / |c2|, with saturation
// and the sign of c1 * c2.
// ----------------------------------------------------------------------------
module pxr_div import pxr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  trig_t                 in_trig,
  input  logic [HEIGHT_W-1:0]   height,
  output logic                  out_valid,
  output angle_pair_t           out_ang,
  output logic signed [RANGE_W-1:0] out_range,
  output logic                  out_sat
);

  localparam int M_W  = 32;
  localparam int R_W  = M_W + 1;
  localparam int Q1_W = 33;
  localparam int Q2_W = RANGE_W;
  localparam int NV   = Q1_W + Q2_W + 3;

  localparam logic [Q1_W-1:0] LIM_POS = Q1_W'((longint'(1) <<< (RANGE_W - 1)) - 1);
  localparam logic [Q1_W-1:0] LIM_NEG = Q1_W'(longint'(1) <<< (RANGE_W - 1));

  typedef struct packed {
    angle_pair_t      ang;
    logic             neg;
    logic             zero;
    logic             sat;
    logic [M_W-1:0]   m1;
    logic [M_W-1:0]   m2;
    logic [R_W-1:0]   r;
    logic [Q1_W-1:0]  q;
    logic [1:0]       ql;
  } dstage_t;

  logic [0:NV-1]           vld;
  dstage_t                 s1 [0:Q1_W];
  dstage_t                 s2 [0:Q2_W];
  dstage_t                 d0;
  dstage_t                 s2_init;
  logic [R_W-1:0]          h_top;
  logic [Q1_W-1:0]         lim;
  logic [Q2_W-1:0]         mag;
  logic signed [ROT_W-1:0] c1_abs;
  logic signed [ROT_W-1:0] c2_abs;

  // Restoring step: shift in one numerator bit, subtract when it fits
  function automatic dstage_t div_step(input dstage_t s, input logic bin, input logic use_m2);
    dstage_t        r;
    logic [R_W-1:0] r2;
    logic [R_W-1:0] m;
    r  = s;
    r2 = {s.r[R_W-2:0], bin};
    m  = use_m2 ? {1'b0, s.m2} : {1'b0, s.m1};
    if (r2 >= m) begin
      r.r = r2 - m;
      r.q = {s.q[Q1_W-2:0], 1'b1};
    end else begin
      r.r = r2;
      r.q = {s.q[Q1_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {in_valid, vld[0:NV-2]};
    end
  end

  // Stage 0: magnitudes, sign, zero test, first overflow test
  always_comb begin
    c1_abs  = in_trig.c1[ROT_W-1] ? -in_trig.c1 : in_trig.c1;
    c2_abs  = in_trig.c2[ROT_W-1] ? -in_trig.c2 : in_trig.c2;
    h_top   = R_W'({height, 5'b0});
    d0.ang  = in_trig.ang;
    d0.neg  = in_trig.c1[ROT_W-1] ^ in_trig.c2[ROT_W-1];
    d0.zero = (in_trig.c1 == '0) || (in_trig.c2 == '0);
    d0.m1   = M_W'(c1_abs);
    d0.m2   = M_W'(c2_abs);
    d0.sat  = (h_top >= R_W'(M_W'(c1_abs)));
    d0.r    = h_top;
    d0.q    = '0;
    d0.ql   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1[0] <= d0;
    end
  end

  // First quotient, one bit per stage; the numerator tail is all zero
  for (genvar k = 0; k < Q1_W; k++) begin : g_q1
    always_ff @(posedge clk) begin
      if (en) begin
        s1[k+1] <= div_step(s1[k], 1'b0, 1'b0);
      end
    end
  end

  // Second divider start: top of the shifted first quotient
  always_comb begin
    s2_init     = s1[Q1_W];
    s2_init.r   = R_W'(s1[Q1_W].q[Q1_W-1:2]);
    s2_init.sat = s1[Q1_W].sat || (R_W'(s1[Q1_W].q[Q1_W-1:2]) >= {1'b0, s1[Q1_W].m2});
    s2_init.ql  = s1[Q1_W].q[1:0];
    s2_init.q   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2[0] <= s2_init;
    end
  end

  // Second quotient: the two low quotient bits come in first, then zeros
  for (genvar k = 0; k < Q2_W; k++) begin : g_q2
    localparam logic USE_QL = (k < 2);
    always_ff @(posedge clk) begin
      if (en) begin
        s2[k+1] <= div_step(s2[k], USE_QL ? s2[k].ql[1-k%2] : 1'b0, 1'b1);
      end
    end
  end

  // Clamp, sign and zero-cosine handling
  always_comb begin
    lim = s2[Q2_W].neg ? LIM_NEG : LIM_POS;
    mag = s2[Q2_W].q[Q2_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ang <= s2[Q2_W].ang;
      if (s2[Q2_W].zero) begin
        out_range <= '0;
        out_sat   <= 1'b0;
      end else if (s2[Q2_W].sat || ({1'b0, mag} > lim)) begin
        out_range <= s2[Q2_W].neg ? -$signed(Q2_W'(lim)) : $signed(Q2_W'(lim));
        out_sat   <= 1'b1;
      end else begin
        out_range <= s2[Q2_W].neg ? -$signed(mag) : $signed(mag);
        out_sat   <= 1'b0;
      end
    end
  end

  assign out_valid = vld[NV-1];

endmodule

[design/pixel_to_ground_range.sv]
// ----------------------------------------------------------------------------
// pixel_to_ground_range
// Ground-plane range of a pixel under a pinhole camera over flat ground.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while no result is parked and returns bearing,
// elevation and ground range for it, in order, one result per pixel. The path
// is made of the two CORDIC pipelines (one step per stage, STEPS_USED + 2 and
// STEPS_USED + 4 stages) and the two dividers (one quotient bit per stage, 68
// stages).
// A result the receiver does not take is parked in an output register and the
// pipeline stops in the next cycle; pixel ready comes straight from that
// register. Nothing is dropped. Registers are written through
// cfg_we/cfg_index/cfg_data and must only change while the pipeline is empty.
// ----------------------------------------------------------------------------
module pixel_to_ground_range import pxr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pxr_pixel_if.sink             pixel,
  pxr_result_if.source          result
);

  cfg_t                      cfg;
  logic                      en;
  logic                      ang_valid;
  angle_pair_t               ang;
  logic                      trig_valid;
  trig_t                     trig;
  logic                      div_valid;
  angle_pair_t               div_ang;
  logic signed [RANGE_W-1:0] div_range;
  logic                      div_sat;
  logic                      skid_valid;
  angle_pair_t               skid_ang;
  logic signed [RANGE_W-1:0] skid_range;
  logic                      skid_sat;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_x <= CENTRE_W'(640);
      cfg.centre_y <= CENTRE_W'(480);
      cfg.scale_x  <= '0;
      cfg.scale_y  <= '0;
      cfg.elev_ofs <= '0;
      cfg.height   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTRE_X: cfg.centre_x <= cfg_data[CENTRE_W-1:0];
        REG_CENTRE_Y: cfg.centre_y <= cfg_data[CENTRE_W-1:0];
        REG_SCALE_X:  cfg.scale_x  <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:  cfg.scale_y  <= cfg_data[SCALE_W-1:0];
        REG_ELEV_OFS: cfg.elev_ofs <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_CAM_HGT:  cfg.height   <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless a result is parked
  assign en          = !skid_valid;
  assign pixel.ready = en;

  pxr_angle u_angle (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel.valid),
    .pixel_x   (pixel.pixel_x),
    .pixel_y   (pixel.pixel_y),
    .cfg       (cfg),
    .out_valid (ang_valid),
    .out_ang   (ang)
  );

  pxr_sincos u_sincos (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ang_valid),
    .in_ang    (ang),
    .out_valid (trig_valid),
    .out_trig  (trig)
  );

  pxr_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (trig_valid),
    .in_trig    (trig),
    .height     (cfg.height),
    .out_valid  (div_valid),
    .out_ang    (div_ang),
    .out_range  (div_range),
    .out_sat    (div_sat)
  );

  // Output register: catches a result that was offered but not taken
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (result.ready) begin
        skid_valid <= 1'b0;
      end
    end else if (div_valid && !result.ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_ang   <= div_ang;
      skid_range <= div_range;
      skid_sat   <= div_sat;
    end
  end

  // Parked result goes first
  assign result.valid           = skid_valid || div_valid;
  assign result.bearing         = skid_valid ? skid_ang.bearing : div_ang.bearing;
  assign result.elevation       = skid_valid ? skid_ang.elevation : div_ang.elevation;
  assign result.range           = skid_valid ? skid_range : div_range;
  assign result.range_saturated = skid_valid ? skid_sat : div_sat;

endmodule

[design/pxr_checker.sv]
// ----------------------------------------------------------------------------
// pxr_checker
// Port-level checks of the pixel-to-ground-range block, bound to the top.
// ----------------------------------------------------------------------------
module pxr_checker import pxr_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [RANGE_W-1:0] range,
  input logic                      range_saturated
);

  // A result that is not taken stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // With no result pending the block takes pixels
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("pixel refused with empty output");

  // A saturated range sits at one of the two limits
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_saturated |->
      (range == $signed(32'h7fffffff)) || (range == $signed(32'h80000000)))
    else $error("saturated range off limit");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pixel_to_ground_range pxr_checker u_pxr_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (pixel.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .range           (result.range),
  .range_saturated (result.range_saturated)
);

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench of pixel_to_ground_range. Pixels go in over a valid/ready channel.
// Every accepted pixel is run through a bit-true model of the two CORDICs and
// the divider, and the expected ranges are queued. Results are compared field
// by field in order. The stimulus starts with a table of directed pixels under
// reset and extreme register settings. It then runs random phases with sender and
// receiver idling, and one long receiver hold that fills the pipeline.
// ----------------------------------------------------------------------------
module tb_top;
  import pxr_pkg::*;

  localparam int  WATCHDOG_LIMIT = 4000;
  localparam int  DRAIN_CYCLES   = 2 * STEPS_USED + 90;
  localparam int  LONG_HOLD      = 500;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = CFG_IDX_W'(7);
  localparam longint PI_Q    = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint TWO_PI  = 64'sd6746518852;
  localparam longint ATAN_TBL [24] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288,
    262144, 131072, 65536, 32768, 16384, 8192,
    4096, 2048, 1024, 512, 256, 128};

  typedef struct {
    logic signed [ANGLE_W-1:0] bearing;
    logic signed [ANGLE_W-1:0] elevation;
    logic signed [RANGE_W-1:0] gnd_range;
    logic                      sat;
  } ground_fix_t;

  typedef struct {
    logic [PIXEL_BITS-1:0] px;
    logic [PIXEL_BITS-1:0] py;
    bit                    known;   // range fields typed in below
    logic signed [RANGE_W-1:0] gnd_range;
    logic                  sat;
  } pixel_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pxr_pixel_if  pixel ();
  pxr_result_if result ();

  pixel_to_ground_range dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixel.sink),
    .result    (result.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register mirror
  logic [CENTRE_W-1:0]        m_centre_x = CENTRE_W'(640);
  logic [CENTRE_W-1:0]        m_centre_y = CENTRE_W'(480);
  logic [SCALE_W-1:0]         m_scale_x  = '0;
  logic [SCALE_W-1:0]         m_scale_y  = '0;
  logic signed [OFFSET_W-1:0] m_elev_ofs = '0;
  logic [HEIGHT_W-1:0]        m_height   = '0;

  ground_fix_t pending_fixes[$];
  int  mismatches = 0;
  int  src_idle_pct = 0;
  int  snk_stall_pct = 0;
  bit  long_hold_go = 1'b0;
  int  hold_left = 0;
  int  quiet_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic longint atan_of(longint y);
    longint x, z, dx, dy;
    x = longint'(1) <<< 25;
    z = 0;
    for (int i = 0; i < STEPS_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end
    end
    return z;
  endfunction

  function automatic longint round_angle(longint z);
    return (z + (longint'(1) <<< (29 - ANGLE_FRAC_BITS))) >>> (30 - ANGLE_FRAC_BITS);
  endfunction

  function automatic longint clamp_angle(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic cos_sin(input longint ang, output longint c, output longint s);
    longint a, x, y, dx, dy;
    bit flip;
    a = ang * (longint'(1) <<< (30 - ANGLE_FRAC_BITS));
    flip = 1'b0;
    a = a % TWO_PI;
    if (a > PI_Q) a -= TWO_PI;
    if (a < -PI_Q) a += TWO_PI;
    if (a > HALF_PI) begin
      a -= PI_Q; flip = 1'b1;
    end else if (a < -HALF_PI) begin
      a += PI_Q; flip = 1'b1;
    end
    x = 64'sd652032874
      + ((64'sd434688583 + (longint'(1) <<< (2 * STEPS_USED - 1))) >>> (2 * STEPS_USED));
    y = 0;
    for (int i = 0; i < STEPS_USED; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (a >= 0) begin
        x -= dx; y += dy; a -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; a += ATAN_TBL[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_ground(input logic [PIXEL_BITS-1:0] px,
                                input logic [PIXEL_BITS-1:0] py,
                                output ground_fix_t fix);
    longint dxh, dyh, brg, elv, cb, sb, ce, se, c1, c2, rng;
    longint unsigned m1, m2, q1, lim, mag;
    bit neg, sat;
    dxh = longint'(m_centre_x) - 2 * longint'(px);
    dyh = longint'(m_centre_y) - 2 * longint'(py);
    brg = clamp_angle(round_angle(atan_of(dxh * longint'(m_scale_x))));
    elv = clamp_angle(round_angle(atan_of(dyh * longint'(m_scale_y)))
                      + longint'(m_elev_ofs));
    cos_sin(brg, cb, sb);
    cos_sin(elv, ce, se);
    c1 = -se;
    c2 = cb;
    rng = 0;
    sat = 1'b0;
    if (c1 != 0 && c2 != 0) begin
      neg = (c1 < 0) != (c2 < 0);
      m1 = c1 < 0 ? -c1 : c1;
      m2 = c2 < 0 ? -c2 : c2;
      q1 = (longint'(m_height) << 38) / m1;
      lim = neg ? 64'd2147483648 : 64'd2147483647;
      if (q1 >= (64'd1 << 33)) begin
        mag = lim; sat = 1'b1;
      end else begin
        mag = (q1 << 30) / m2;
        if (mag > lim) begin
          mag = lim; sat = 1'b1;
        end
      end
      rng = neg ? -longint'(mag) : longint'(mag);
    end
    fix.bearing   = ANGLE_W'(brg);
    fix.elevation = ANGLE_W'(elv);
    fix.gnd_range = RANGE_W'(rng);
    fix.sat       = sat;
  endtask

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] %s mismatch: got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // receiver: stalls, long hold, result compare, watchdog
  always @(posedge clk) begin
    ground_fix_t want;
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      if (long_hold_go) begin
        hold_left = LONG_HOLD;
        long_hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
      if (result.valid && result.ready) begin
        if (pending_fixes.size() == 0) begin
          report_mismatch("unexpected result item", 1, 0);
        end else begin
          want = pending_fixes.pop_front();
          if (result.bearing !== want.bearing)
            report_mismatch("bearing", result.bearing, want.bearing);
          if (result.elevation !== want.elevation)
            report_mismatch("elevation", result.elevation, want.elevation);
          if (result.range !== want.gnd_range)
            report_mismatch("range", result.range, want.gnd_range);
          if (result.range_saturated !== want.sat)
            report_mismatch("range_saturated", result.range_saturated, want.sat);
        end
      end
    end
    if ((pixel.valid && pixel.ready) || (result.valid && result.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CENTRE_X: m_centre_x = val[CENTRE_W-1:0];
      REG_CENTRE_Y: m_centre_y = val[CENTRE_W-1:0];
      REG_SCALE_X:  m_scale_x  = val[SCALE_W-1:0];
      REG_SCALE_Y:  m_scale_y  = val[SCALE_W-1:0];
      REG_ELEV_OFS: m_elev_ofs = val[OFFSET_W-1:0];
      REG_CAM_HGT:  m_height   = val[HEIGHT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                         input logic [CFG_DATA_W-1:0] sx, input logic [CFG_DATA_W-1:0] sy,
                         input logic [CFG_DATA_W-1:0] ofs, input logic [CFG_DATA_W-1:0] h);
    write_reg(REG_CENTRE_X, cx);
    write_reg(REG_CENTRE_Y, cy);
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    write_reg(REG_ELEV_OFS, ofs);
    write_reg(REG_CAM_HGT, h);
    end_writes();
  endtask

  // offer one pixel, with random idle cycles ahead of it
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] px, input logic [PIXEL_BITS-1:0] py,
                            input bit known, input pixel_row_t row);
    ground_fix_t fix;
    while ($urandom_range(99) < src_idle_pct) begin
      pixel.valid <= 1'b0;
      @(posedge clk);
    end
    pixel.valid   <= 1'b1;
    pixel.pixel_x <= px;
    pixel.pixel_y <= py;
    do @(posedge clk); while (!pixel.ready);
    predict_ground(px, py, fix);
    if (known) begin
      fix.gnd_range = row.gnd_range;
      fix.sat       = row.sat;
    end
    pending_fixes.insert(pending_fixes.size(), fix);
  endtask

  task automatic drain();
    pixel.valid <= 1'b0;
    while (pending_fixes.size() != 0) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_scale();
    case ($urandom_range(3))
      0: return CFG_DATA_W'($urandom);
      1: return CFG_DATA_W'($urandom_range(65535));
      2: return '0;
      default: return {CFG_DATA_W{1'b1}};
    endcase
  endfunction

  task automatic random_config();
    int ofs;
    ofs = int'($urandom_range(51472)) - 25736;
    if ($urandom_range(4) == 0) ofs = $urandom_range(1) ? 25736 : -25736;
    set_all(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom), pick_scale(), pick_scale(),
            CFG_DATA_W'(ofs), CFG_DATA_W'($urandom));
  endtask

  task automatic random_pixels(input int n);
    pixel_row_t none;
    logic [PIXEL_BITS-1:0] px, py;
    none = '{default: '0};
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        // near the optical centre, where the angles are small
        px = PIXEL_BITS'((m_centre_x >> 1) + $urandom_range(8) - 4);
        py = PIXEL_BITS'((m_centre_y >> 1) + $urandom_range(8) - 4);
      end else begin
        px = PIXEL_BITS'($urandom);
        py = PIXEL_BITS'($urandom);
      end
      send_pixel(px, py, 1'b0, none);
    end
  endtask

  // directed pixels; range fields typed in only where the height is zero
  pixel_row_t directed_rows [12] = '{
    '{0, 0, 1, 0, 0},
    '{2047, 2047, 1, 0, 0},
    '{0, 2047, 1, 0, 0},
    '{2047, 0, 1, 0, 0},
    '{320, 240, 1, 0, 0},
    '{1365, 682, 0, 0, 0},
    '{0, 0, 0, 0, 0},
    '{2047, 2047, 0, 0, 0},
    '{1024, 1024, 0, 0, 0},
    '{2047, 0, 0, 0, 0},
    '{0, 2047, 0, 0, 0},
    '{1023, 1023, 0, 0, 0}
  };

  // ---------------------------------------------------------------- stimulus
  initial begin
    pixel.valid   = 1'b0;
    pixel.pixel_x = '0;
    pixel.pixel_y = '0;
    result.ready  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset values, zero height: range is zero
    for (int i = 0; i < 5; i++)
      send_pixel(directed_rows[i].px, directed_rows[i].py, 1'b1, directed_rows[i]);
    drain();

    // all extremes high, angles clamp and quotients saturate
    set_all({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}},
            CFG_DATA_W'(25736), CFG_DATA_W'(65535));
    for (int i = 5; i < 12; i++)
      send_pixel(directed_rows[i].px, directed_rows[i].py, 1'b0, directed_rows[i]);
    drain();

    // extremes low, negative offset; unused indexes must change nothing
    set_all('0, '0, CFG_DATA_W'(1), '0, CFG_DATA_W'(-25736), CFG_DATA_W'(1));
    write_reg(IDX_SPARE_LO, {CFG_DATA_W{1'b1}});
    write_reg(IDX_SPARE_HI, CFG_DATA_W'($urandom));
    end_writes();
    for (int i = 5; i < 12; i++)
      send_pixel(directed_rows[i].px, directed_rows[i].py, 1'b0, directed_rows[i]);
    drain();

    // random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      src_idle_pct  = (ph == 1) ? 73 : (ph == 3) ? 25 : 0;
      snk_stall_pct = (ph == 2) ? 73 : (ph == 3) ? 25 : 0;
      random_config();
      random_pixels(90);
      drain();          // sender waits for every result
      random_config();
      random_pixels(90);
      drain();
    end

    // long receiver hold while pixels stream back to back
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    random_config();
    long_hold_go = 1'b1;
    random_pixels(200);
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_fixes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pxr_pkg.sv
design/pxr_if.sv
design/pxr_angle.sv
design/pxr_sincos.sv
design/pxr_div.sv
design/pixel_to_ground_range.sv
design/pxr_checker.sv
tb/tb_top.sv
